[src/exptok_pkg.sv]
// ----------------------------------------------------------------------------
// exptok_pkg
// Shared types, codes and character helpers of the expression tokenizer.
// ----------------------------------------------------------------------------
package exptok_pkg;

   localparam int POS_W = 16;
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
   localparam logic [15:0] TOKEN_MAX = 16'hFFFF;
   localparam logic [15:0] CAP_RESET = 16'd128;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

   localparam logic [4:0] KIND_INT     = 5'd0;
   localparam logic [4:0] KIND_IDENT   = 5'd1;
   localparam logic [4:0] KIND_AND     = 5'd2;
   localparam logic [4:0] KIND_OR      = 5'd3;
   localparam logic [4:0] KIND_NOT     = 5'd4;
   localparam logic [4:0] KIND_EQ      = 5'd5;
   localparam logic [4:0] KIND_NE      = 5'd6;
   localparam logic [4:0] KIND_LT      = 5'd7;
   localparam logic [4:0] KIND_LE      = 5'd8;
   localparam logic [4:0] KIND_GT      = 5'd9;
   localparam logic [4:0] KIND_GE      = 5'd10;
   localparam logic [4:0] KIND_LPAREN  = 5'd11;
   localparam logic [4:0] KIND_RPAREN  = 5'd12;
   localparam logic [4:0] KIND_PLUS    = 5'd13;
   localparam logic [4:0] KIND_MINUS   = 5'd14;
   localparam logic [4:0] KIND_STAR    = 5'd15;
   localparam logic [4:0] KIND_SLASH   = 5'd16;
   localparam logic [4:0] KIND_PERCENT = 5'd17;
   localparam logic [4:0] KIND_ERROR   = 5'd18;
   localparam logic [4:0] KIND_EOF     = 5'd19;

   localparam logic [2:0] PEND_NONE = 3'd0;
   localparam logic [2:0] PEND_AMP  = 3'd1;
   localparam logic [2:0] PEND_BAR  = 3'd2;
   localparam logic [2:0] PEND_BANG = 3'd3;
   localparam logic [2:0] PEND_EQ   = 3'd4;
   localparam logic [2:0] PEND_LT   = 3'd5;
   localparam logic [2:0] PEND_GT   = 3'd6;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_NUM  = 4'b0010,
      MODE_WORD = 4'b0100,
      MODE_PEND = 4'b1000
   } mode_type;

   typedef struct packed {
      logic       op;
      logic [7:0] ch;
   } req_item_type;

   typedef struct packed {
      logic [4:0]         kind;
      logic [15:0]        start_pos;
      logic [15:0]        token_len;
      logic signed [31:0] int_value;
      logic [15:0]        token_index;
      logic               kept;
      logic               last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } step_type;

   function automatic logic [15:0] pos_to16(logic [POS_W-1:0] p);
      logic [31:0] w;
      w = 32'(p);
      return w[15:0];
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
   endfunction

   function automatic logic [2:0] pend_code(logic [7:0] c);
      logic [2:0] p;
      case (c)
         "&": p = PEND_AMP;
         "|": p = PEND_BAR;
         "!": p = PEND_BANG;
         "=": p = PEND_EQ;
         "<": p = PEND_LT;
         ">": p = PEND_GT;
         default: p = PEND_NONE;
      endcase
      return p;
   endfunction

   function automatic logic [4:0] char_kind(logic [7:0] c);
      logic [4:0] k;
      case (c)
         "(": k = KIND_LPAREN;
         ")": k = KIND_RPAREN;
         "+": k = KIND_PLUS;
         "-": k = KIND_MINUS;
         "*": k = KIND_STAR;
         "/": k = KIND_SLASH;
         "%": k = KIND_PERCENT;
         default: k = KIND_ERROR;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] pend_single(logic [2:0] p);
      logic [4:0] k;
      case (p)
         PEND_BANG: k = KIND_NOT;
         PEND_LT:   k = KIND_LT;
         PEND_GT:   k = KIND_GT;
         default:   k = KIND_ERROR;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] pend_double(logic [2:0] p);
      logic [4:0] k;
      case (p)
         PEND_AMP:  k = KIND_AND;
         PEND_BAR:  k = KIND_OR;
         PEND_BANG: k = KIND_NE;
         PEND_EQ:   k = KIND_EQ;
         PEND_LT:   k = KIND_LE;
         PEND_GT:   k = KIND_GE;
         default:   k = KIND_ERROR;
      endcase
      return k;
   endfunction

   // character that closes a two-character operator, zero when none
   function automatic logic [7:0] pend_second(logic [2:0] p);
      logic [7:0] c;
      case (p)
         PEND_AMP:  c = "&";
         PEND_BAR:  c = "|";
         PEND_BANG: c = "=";
         PEND_EQ:   c = "=";
         PEND_LT:   c = "=";
         PEND_GT:   c = "=";
         default:   c = 8'h00;
      endcase
      return c;
   endfunction

   // chars[0] holds the first character of the word
   function automatic logic [4:0] fold_word(logic [2:0][7:0] chars, logic [2:0] len);
      logic [23:0] w3;
      logic [15:0] w2;
      logic [4:0]  k;
      w3 = {chars[0], chars[1], chars[2]};
      w2 = {chars[0], chars[1]};
      k = KIND_IDENT;
      if (len == 3'd3) begin
         if (w3 == "and") k = KIND_AND;
         else if (w3 == "not") k = KIND_NOT;
      end else if (len == 3'd2) begin
         if (w2 == "or") k = KIND_OR;
         else if (w2 == "eq") k = KIND_EQ;
         else if (w2 == "ne") k = KIND_NE;
         else if (w2 == "lt") k = KIND_LT;
         else if (w2 == "le") k = KIND_LE;
         else if (w2 == "gt") k = KIND_GT;
         else if (w2 == "ge") k = KIND_GE;
      end
      return k;
   endfunction

   function automatic logic [15:0] sat_inc16(logic [15:0] v);
      return (v == TOKEN_MAX) ? v : v + 16'd1;
   endfunction

endpackage

[src/exptok_if.sv]
// ----------------------------------------------------------------------------
// exptok_if
// Valid/ready channels of the expression tokenizer: character in, token out.
// ----------------------------------------------------------------------------
interface exptok_req_if import exptok_pkg::*; ;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] ch;

   modport source (output valid, output op, output ch, input ready);
   modport sink (input valid, input op, input ch, output ready);
endinterface

interface exptok_rsp_if import exptok_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [4:0]         kind;
   logic [15:0]        start_pos;
   logic [15:0]        token_len;
   logic signed [31:0] int_value;
   logic [15:0]        token_index;
   logic               kept;
   logic               last;

   modport source (output valid, output kind, output start_pos, output token_len,
                   output int_value, output token_index, output kept, output last,
                   input ready);
   modport sink (input valid, input kind, input start_pos, input token_len,
                 input int_value, input token_index, input kept, input last,
                 output ready);
endinterface

[src/expression_tokenizer.sv]
// A token enters the result queue at the edge that accepts the item and is
//   offered on rsp_port once it reaches the head of the queue.
// Throughput: one item per cycle while items give at most one token and
//   rsp_port.ready stays high; the tokens of a two-token item leave one a cycle.
// req_port.ready drops while the four-entry result queue has under two free slots.
// Reset (synchronous, high): scan state cleared, queue empty, token cap 128.
// ----------------------------------------------------------------------------
// expression_tokenizer
// Streaming lexer top level: config register, scanner and result queue.
// ----------------------------------------------------------------------------
module expression_tokenizer import exptok_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [15:0]   csr_wdata,
   exptok_req_if.sink    req_port,
   exptok_rsp_if.source  rsp_port
);

   logic [15:0]   cap_ff;
   logic          accept;
   logic          space;
   req_item_type  item;
   step_type      step;
   rsp_item_type  head;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
      end
   end

   assign req_port.ready = space;
   assign accept = req_port.valid && space;
   assign item.op = req_port.op;
   assign item.ch = req_port.ch;

   exptok_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (item),
      .token_cap (cap_ff),
      .step      (step)
   );

   exptok_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .step      (step),
      .space     (space),
      .out_valid (rsp_port.valid),
      .out_ready (rsp_port.ready),
      .out_item  (head)
   );

   assign rsp_port.kind        = head.kind;
   assign rsp_port.start_pos   = head.start_pos;
   assign rsp_port.token_len   = head.token_len;
   assign rsp_port.int_value   = head.int_value;
   assign rsp_port.token_index = head.token_index;
   assign rsp_port.kept        = head.kept;
   assign rsp_port.last        = head.last;

endmodule

[src/exptok_core.sv]
// ----------------------------------------------------------------------------
// exptok_core
// Scan state and combinational step logic: up to two tokens per accepted item.
// ----------------------------------------------------------------------------
module exptok_core import exptok_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_item_type item,
   input  logic [15:0]  token_cap,
   output step_type     step
);

   mode_type          mode_ff, mode_in;
   logic [2:0]        pend_ff, pend_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  start_ff, start_in;
   logic [31:0]       acc_ff, acc_in;
   logic [2:0][7:0]   chars_ff, chars_in;
   logic [2:0]        wlen_ff, wlen_in;
   logic [15:0]       count_ff, count_in;

   logic [POS_W-1:0]  pos_adv;
   logic [POS_W-1:0]  open_len;
   logic [2:0]        pend_cur;
   logic [2:0]        pend_new;
   logic [31:0]       digit_val;
   logic              ch_digit;
   logic              ch_alpha;

   // candidate tokens: a is the flushed or paired token, b the new one
   logic              a_valid, b_valid;
   rsp_item_type      tok_a, tok_b;
   logic [15:0]       idx_a, idx_b;

   assign pos_adv   = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
   assign open_len  = pos_ff - start_ff;
   assign pend_cur  = (pend_ff > PEND_GT) ? PEND_NONE : pend_ff;
   assign pend_new  = pend_code(item.ch);
   assign digit_val = {28'd0, item.ch[3:0]};
   assign ch_digit  = is_digit(item.ch);
   assign ch_alpha  = is_alpha(item.ch);

   always_comb begin
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      acc_in   = acc_ff;
      chars_in = chars_ff;
      wlen_in  = wlen_ff;
      a_valid  = 1'b0;
      b_valid  = 1'b0;
      tok_a    = '0;
      tok_b    = '0;

      // open token, as flushed when the next character does not extend it
      tok_a.start_pos = pos_to16(start_ff);
      tok_a.token_len = pos_to16(open_len);
      case (mode_ff)
         MODE_NUM: begin
            a_valid = 1'b1;
            tok_a.kind = KIND_INT;
            tok_a.int_value = acc_ff;
         end
         MODE_WORD: begin
            a_valid = 1'b1;
            tok_a.kind = fold_word(chars_ff, wlen_ff);
         end
         MODE_PEND: begin
            a_valid = 1'b1;
            tok_a.kind = pend_single(pend_cur);
            tok_a.token_len = 16'd1;
         end
         default: begin
            a_valid = 1'b0;
         end
      endcase

      if (item.op == OP_END) begin
         b_valid = 1'b1;
         tok_b.kind = KIND_EOF;
         tok_b.start_pos = pos_to16(pos_ff);
         mode_in  = MODE_IDLE;
         pend_in  = PEND_NONE;
         pos_in   = '0;
         start_in = '0;
         acc_in   = '0;
         chars_in = '0;
         wlen_in  = '0;
      end else if ((mode_ff == MODE_NUM) && ch_digit) begin
         a_valid = 1'b0;
         acc_in  = 32'(acc_ff * 32'd10) + digit_val;
         pos_in  = pos_adv;
      end else if ((mode_ff == MODE_WORD) && (ch_alpha || ch_digit)) begin
         a_valid = 1'b0;
         if (wlen_ff < 3'd3) chars_in[wlen_ff[1:0]] = item.ch;
         if (wlen_ff < 3'd4) wlen_in = wlen_ff + 3'd1;
         pos_in = pos_adv;
      end else if ((mode_ff == MODE_PEND) && (pend_cur != PEND_NONE) &&
                   (item.ch == pend_second(pend_cur))) begin
         tok_a.kind = pend_double(pend_cur);
         tok_a.token_len = 16'd2;
         mode_in = MODE_IDLE;
         pos_in  = pos_adv;
      end else begin
         mode_in = MODE_IDLE;
         pos_in  = pos_adv;
         if (is_blank(item.ch)) begin
            mode_in = MODE_IDLE;
         end else if (ch_digit) begin
            mode_in  = MODE_NUM;
            start_in = pos_ff;
            acc_in   = digit_val;
         end else if (ch_alpha) begin
            mode_in  = MODE_WORD;
            start_in = pos_ff;
            chars_in = {8'h00, 8'h00, item.ch};
            wlen_in  = 3'd1;
         end else if (pend_new != PEND_NONE) begin
            mode_in  = MODE_PEND;
            pend_in  = pend_new;
            start_in = pos_ff;
         end else begin
            b_valid = 1'b1;
            tok_b.kind = char_kind(item.ch);
            tok_b.start_pos = pos_to16(pos_ff);
            tok_b.token_len = 16'd1;
         end
      end
   end

   // running token numbers, second token follows the first
   assign idx_a = count_ff;
   assign idx_b = a_valid ? sat_inc16(count_ff) : count_ff;

   always_comb begin
      rsp_item_type ra;
      rsp_item_type rb;
      ra = tok_a;
      rb = tok_b;
      ra.token_index = idx_a;
      ra.kept = (idx_a < token_cap);
      rb.token_index = idx_b;
      rb.kept = (idx_b < token_cap);
      rb.last = 1'b1;
      ra.last = !b_valid;
      step.count  = {1'b0, a_valid} + {1'b0, b_valid};
      step.first  = a_valid ? ra : rb;
      step.second = rb;
      if (item.op == OP_END) count_in = '0;
      else if (b_valid) count_in = sat_inc16(idx_b);
      else if (a_valid) count_in = sat_inc16(count_ff);
      else count_in = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pend_ff  <= PEND_NONE;
         pos_ff   <= '0;
         start_ff <= '0;
         acc_ff   <= '0;
         chars_ff <= '0;
         wlen_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         acc_ff   <= acc_in;
         chars_ff <= chars_in;
         wlen_ff  <= wlen_in;
         count_ff <= count_in;
      end
   end

endmodule

[src/exptok_rsp_fifo.sv]
// ----------------------------------------------------------------------------
// exptok_rsp_fifo
// Small result queue: takes up to two tokens a cycle, hands out one.
// ----------------------------------------------------------------------------
module exptok_rsp_fifo import exptok_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  step_type     step,
   output logic         space,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   rsp_item_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]         wr_ff, wr_in;
   logic [FIFO_AW-1:0]         rd_ff, rd_in;
   logic [FIFO_CW-1:0]         cnt_ff, cnt_in;
   logic [FIFO_AW-1:0]         wr_next;
   logic [1:0]                 n_push;
   logic                       pop;

   assign n_push    = push ? step.count : 2'd0;
   assign out_valid = (cnt_ff != '0);
   assign pop       = out_valid && out_ready;
   // room for a worst-case item of two tokens
   assign space     = (cnt_ff <= FIFO_CW'(FIFO_DEPTH - 2));
   assign out_item  = mem_ff[rd_ff];
   assign wr_next   = wr_ff + 1'b1;

   assign wr_in  = wr_ff + FIFO_AW'(n_push);
   assign rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + FIFO_CW'(n_push) - FIFO_CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) mem_ff[wr_ff] <= step.first;
      if (n_push == 2'd2) mem_ff[wr_next] <= step.second;
   end

endmodule

[src/exptok_checker.sv]
// ----------------------------------------------------------------------------
// exptok_checker
// Port-level checks on the token output of the expression tokenizer.
// ----------------------------------------------------------------------------
module exptok_checker import exptok_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [4:0]         rsp_kind,
   input  logic [15:0]        rsp_token_len,
   input  logic signed [31:0] rsp_int_value,
   input  logic               rsp_last
);

   // a stalled token stays offered with its kind and value unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_int_value))
      else $error("token changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("token offered right after reset");

   // end of expression closes the item with an empty token
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_EOF) |-> rsp_last && (rsp_token_len == 16'd0))
      else $error("eof token not last or not empty");

   a_value_int_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_INT) |-> (rsp_int_value == 32'sd0))
      else $error("value on a non-integer token");

endmodule

bind expression_tokenizer exptok_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_port.valid),
   .rsp_ready     (rsp_port.ready),
   .rsp_kind      (rsp_port.kind),
   .rsp_token_len (rsp_port.token_len),
   .rsp_int_value (rsp_port.int_value),
   .rsp_last      (rsp_port.last)
);
